// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port checker of the RC6 CFB-8 core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RC6_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");

// Property checked on every clock edge, reset included.
`define RC6_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m failed");

`endif

// ===== rtl/core/rc6cfb_pkg.sv =====
// Shared types and constants of the RC6-32 CFB-8 stream decryption core.
// No dependencies; imported by every module of the core.
`default_nettype none

package rc6cfb_pkg;

  localparam int KEY_WORDS  = 44;
  localparam int KIW        = 6;   // key word index width
  localparam int CNTW       = 6;   // width of the pass-bit count
  localparam int LGW        = 5;   // log2 of the word size
  localparam int ROUNDS_DEF = 20;
  localparam int HIST_BYTES = 16;

  localparam int IN_TDW   = 48;
  localparam int OUT_TDW  = 16;
  localparam int OUT_USED = 10;

  // Expected inverted parity per key word, bit i for word i.
  localparam logic [KEY_WORDS-1:0] PARITY_TABLE =
    44'b1011_0010_0010_0010_0011_1000_1011_0110_0100_0101_0110;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_ROUND,
    ST_FIN,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic           en;
    logic [KIW-1:0] idx;
    logic [31:0]    word;
  } key_wr_t;

  typedef struct packed {
    logic word_ok;      // parity result of the word on the write port
    logic valid_after;  // all words pass once this write lands
    logic key_valid;    // all words pass now
  } key_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rc6cfb_key_store.sv =====
// Round key memory (one write, two registered reads) with per-word parity pass bits.
// Depends on rc6cfb_pkg.
`default_nettype none

module rc6cfb_key_store
  import rc6cfb_pkg::*;
#(
  parameter int KSAW = 7
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire key_wr_t         wr,
  input  wire logic [KSAW-1:0] rd_addr0,
  input  wire logic [KSAW-1:0] rd_addr1,
  output logic      [31:0]     rd_data0,
  output logic      [31:0]     rd_data1,
  output key_stat_t            stat
);

  logic [31:0]          mem [KEY_WORDS];
  logic [31:0]          rd_q0_r, rd_q1_r;
  logic                 rd_ok0_r, rd_ok1_r;
  logic [KEY_WORDS-1:0] good_r, good_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic                 wr_in_range;
  logic                 rd_in0, rd_in1;

  assign wr_in_range = (wr.idx < KIW'(KEY_WORDS));
  assign rd_in0      = (rd_addr0 < KSAW'(KEY_WORDS));
  assign rd_in1      = (rd_addr1 < KSAW'(KEY_WORDS));

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr.idx] <= wr.word;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok0_r <= rd_in0;
    rd_ok1_r <= rd_in1;
    if (rd_in0) begin
      rd_q0_r <= mem[rd_addr0[KIW-1:0]];
    end
    if (rd_in1) begin
      rd_q1_r <= mem[rd_addr1[KIW-1:0]];
    end
  end

  // Schedule entries past the store read as zero.
  assign rd_data0 = rd_ok0_r ? rd_q0_r : 32'h0;
  assign rd_data1 = rd_ok1_r ? rd_q1_r : 32'h0;

  always_comb begin
    stat.word_ok = wr_in_range && ((~^wr.word) == PARITY_TABLE[wr.idx]);
    good_nxt     = good_r;
    cnt_nxt      = cnt_r;
    if (wr.en && wr_in_range) begin
      good_nxt[wr.idx] = stat.word_ok;
      cnt_nxt = cnt_r - CNTW'(good_r[wr.idx]) + CNTW'(stat.word_ok);
    end
    stat.valid_after = (cnt_nxt == CNTW'(KEY_WORDS));
    stat.key_valid   = (cnt_r == CNTW'(KEY_WORDS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r <= '0;
      cnt_r  <= '0;
    end else begin
      good_r <= good_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc6cfb_round.sv =====
// One RC6-32 encryption round: two x(2x+1) products, rotations and key adds.
// Depends on rc6cfb_pkg.
`default_nettype none

module rc6cfb_round
  import rc6cfb_pkg::*;
(
  input  wire logic [31:0] a_in,
  input  wire logic [31:0] b_in,
  input  wire logic [31:0] c_in,
  input  wire logic [31:0] d_in,
  input  wire logic [31:0] key_even,
  input  wire logic [31:0] key_odd,
  output logic      [31:0] a_out,
  output logic      [31:0] b_out,
  output logic      [31:0] c_out,
  output logic      [31:0] d_out
);

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [LGW-1:0] s);
    logic [63:0] wide;
    wide = {v, v} << s;
    return wide[63:32];
  endfunction

  logic [31:0] prod_b, prod_d, t, u, na, nc;

  assign prod_b = b_in * {b_in[30:0], 1'b1};
  assign prod_d = d_in * {d_in[30:0], 1'b1};
  assign t      = rotl(prod_b, LGW'(LGW));
  assign u      = rotl(prod_d, LGW'(LGW));
  assign na     = rotl(a_in ^ t, u[LGW-1:0]) + key_even;
  assign nc     = rotl(c_in ^ u, t[LGW-1:0]) + key_odd;

  assign a_out = b_in;
  assign b_out = nc;
  assign c_out = d_in;
  assign d_out = na;

endmodule

`default_nettype wire

// ===== rtl/core/rc6_cfb8_stream_decrypt_core.sv =====
// RC6-32 CFB-8 byte stream decryption core, top level.
// Depends on rc6cfb_pkg, rc6cfb_key_store and rc6cfb_round.
//
// Usage: requests enter on in_* (tuser = action). A key load request writes one
// of the 44 round key words and answers with its parity verdict and key_valid.
// A decrypt request encrypts the 16-byte ciphertext history, XORs its low byte
// with cipher_byte and answers with the plain byte; start_of_stream clears the
// history first. One answer per request leaves on out_*.
// Requests are taken one at a time. A decrypt runs from accept to the next accept
// through an initial key add, ROUNDS passes through the single round unit, a
// final add and the hand-off; a key load goes straight to the hand-off.
// Reset clears the history, the pass bits and the output valid flag; the key
// words themselves are not cleared and must be loaded before decrypting.
// Stall: the output register holds an answer until out_tready; the core still
// takes the next request and parks its answer until the register frees up.
`default_nettype none

module rc6_cfb8_stream_decrypt_core
  import rc6cfb_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  // [5:0] key_index, [37:6] key_word, [45:38] cipher_byte,
  // [46] start_of_stream, [47] zero
  input  wire logic [IN_TDW-1:0]  in_tdata,
  // [0] action
  input  wire logic               in_tuser,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  // [7:0] plain_byte, [8] word_parity_ok, [9] key_valid, [15:10] zero
  output logic [OUT_TDW-1:0]      out_tdata
);

  localparam int RCW  = $clog2(ROUNDS + 1);
  localparam int KSAW = (RCW + 2 > KIW) ? RCW + 2 : KIW;

  logic [KIW-1:0] in_key_index;
  logic [31:0]    in_key_word;
  logic [7:0]     in_cipher_byte;
  logic           in_start;
  logic           in_action;

  assign in_key_index   = in_tdata[5:0];
  assign in_key_word    = in_tdata[37:6];
  assign in_cipher_byte = in_tdata[45:38];
  assign in_start       = in_tdata[46];
  assign in_action      = in_tuser;

  seq_state_t       state_r, state_nxt;
  logic [31:0]      a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [7:0]       hist_r [HIST_BYTES];
  logic [7:0]       hist_nxt [HIST_BYTES];
  logic [7:0]       hist_eff [HIST_BYTES];
  logic [7:0]       cbyte_r, cbyte_nxt;
  logic [RCW-1:0]   rnd_r, rnd_nxt;
  logic [7:0]       res_byte_r, res_byte_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic             res_kv_r, res_kv_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDW-1:0] out_data_r, out_data_nxt;
  logic [RCW:0]     rd_idx;
  logic [KSAW-1:0]  rd_addr0, rd_addr1;
  logic [31:0]      key_rd0, key_rd1;
  logic [31:0]      rnd_a, rnd_b, rnd_c, rnd_d;
  logic [31:0]      a_fin;
  key_wr_t          key_wr;
  key_stat_t        key_stat;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign key_wr.en   = in_tvalid && in_tready && (in_action == ACT_LOAD);
  assign key_wr.idx  = in_key_index;
  assign key_wr.word = in_key_word;

  // Round i uses key words 2i and 2i+1; fetch them in the cycle before.
  assign rd_addr0 = KSAW'({rd_idx, 1'b0});
  assign rd_addr1 = KSAW'({rd_idx, 1'b1});

  rc6cfb_key_store #(
    .KSAW(KSAW)
  ) u_keys (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (key_wr),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .rd_data0(key_rd0),
    .rd_data1(key_rd1),
    .stat    (key_stat)
  );

  rc6cfb_round u_round (
    .a_in    (a_r),
    .b_in    (b_r),
    .c_in    (c_r),
    .d_in    (d_r),
    .key_even(key_rd0),
    .key_odd (key_rd1),
    .a_out   (rnd_a),
    .b_out   (rnd_b),
    .c_out   (rnd_c),
    .d_out   (rnd_d)
  );

  assign a_fin = a_r + key_rd0;

  always_comb begin
    for (int i = 0; i < HIST_BYTES; i++) begin
      hist_eff[i] = in_start ? 8'h00 : hist_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    hist_nxt      = hist_r;
    cbyte_nxt     = cbyte_r;
    rnd_nxt       = rnd_r;
    res_byte_nxt  = res_byte_r;
    res_ok_nxt    = res_ok_r;
    res_kv_nxt    = res_kv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    rd_idx        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_action == ACT_LOAD) begin
            res_byte_nxt = 8'h00;
            res_ok_nxt   = key_stat.word_ok;
            res_kv_nxt   = key_stat.valid_after;
            state_nxt    = ST_DONE;
          end else begin
            a_nxt = {hist_eff[3], hist_eff[2], hist_eff[1], hist_eff[0]};
            b_nxt = {hist_eff[7], hist_eff[6], hist_eff[5], hist_eff[4]};
            c_nxt = {hist_eff[11], hist_eff[10], hist_eff[9], hist_eff[8]};
            d_nxt = {hist_eff[15], hist_eff[14], hist_eff[13], hist_eff[12]};
            // Shift the history now; A..D already hold the old copy.
            for (int i = 0; i < HIST_BYTES - 1; i++) begin
              hist_nxt[i] = hist_eff[i+1];
            end
            hist_nxt[HIST_BYTES-1] = in_cipher_byte;
            cbyte_nxt = in_cipher_byte;
            state_nxt = ST_PRE;
          end
        end
      end
      ST_PRE: begin
        b_nxt     = b_r + key_rd0;
        d_nxt     = d_r + key_rd1;
        rd_idx    = (RCW+1)'(1);
        rnd_nxt   = RCW'(1);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        a_nxt  = rnd_a;
        b_nxt  = rnd_b;
        c_nxt  = rnd_c;
        d_nxt  = rnd_d;
        rd_idx = {1'b0, rnd_r} + (RCW+1)'(1);
        if (rnd_r == RCW'(ROUNDS)) begin
          state_nxt = ST_FIN;
        end else begin
          rnd_nxt = rnd_r + RCW'(1);
        end
      end
      ST_FIN: begin
        res_byte_nxt = cbyte_r ^ a_fin[7:0];
        res_ok_nxt   = 1'b0;
        res_kv_nxt   = key_stat.key_valid;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_TDW-OUT_USED)'(0), res_kv_r, res_ok_r, res_byte_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_BYTES; i++) begin
        hist_r[i] <= 8'h00;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hist_r      <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    cbyte_r    <= cbyte_nxt;
    rnd_r      <= rnd_nxt;
    res_byte_r <= res_byte_nxt;
    res_ok_r   <= res_ok_nxt;
    res_kv_r   <= res_kv_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc6cfb_port_checker.sv =====
// Port-level checks of the RC6 CFB-8 core, bound to the top level.
// Depends on rc6cfb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rc6cfb_port_checker
  import rc6cfb_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [OUT_TDW-1:0] out_tdata
);

  // Hold a stalled answer and its contents.
  `RC6_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `RC6_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  // One request at a time: the core is busy right after taking one.
  `RC6_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  // Reset drops any pending answer.
  `RC6_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid)

endmodule

bind rc6_cfb8_stream_decrypt_core rc6cfb_port_checker u_port_checker (.*);

`default_nettype wire
